/* src/stxrx_pkg.sv */
// Package for the STX/ETX frame receiver: parse phases, status codes and framing bytes.
`default_nettype none

package stxrx_pkg;

    // Framing bytes
    localparam logic [7:0] STX_BYTE = 8'hF0;
    localparam logic [7:0] ETX_BYTE = 8'hFE;

    // Reset value of the gap timeout register
    localparam logic [15:0] GAP_TIMEOUT_RESET = 16'd100;

    // Configuration register indexes
    localparam logic CFG_ENABLE  = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    // Input word kinds
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Frame status reported in the ETX position
    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_GOOD    = 2'd1,
        ST_BAD_ETX = 2'd2,
        ST_BAD_SUM = 2'd3
    } status_t;

    // Parse phases
    typedef enum logic [2:0] {
        PH_STX   = 3'd0,
        PH_TYPE  = 3'd1,
        PH_CMD   = 3'd2,
        PH_LENL  = 3'd3,
        PH_LENH  = 3'd4,
        PH_DATA  = 3'd5,
        PH_CHECK = 3'd6,
        PH_ETX   = 3'd7
    } phase_t;

    // Result word as carried on the master-side tdata
    typedef struct packed {
        logic [4:0]  pad;
        logic        gap_restart;
        status_t     frame_status;
        logic [15:0] frame_length;
        logic [7:0]  frame_command;
        logic [7:0]  frame_type;
        logic [7:0]  payload_byte;
    } result_t;

endpackage

`default_nettype wire

/* src/stx_etx_frame_receiver.sv */
// STX/ETX frame receiver: byte-wise parser with XOR checksum and idle-gap restart.
//
// Usage:
//   The slave-side channel carries one word per cycle: a received byte
//   (tuser = 0) or one time tick (tuser = 1). Ticks advance a saturating idle
//   counter and give no result. Each byte taken while the receiver is enabled
//   gives exactly one result word on the master-side channel: the payload
//   byte (tuser marks it as payload, tlast marks the last payload byte), the
//   held header fields, the frame status in the ETX position and a flag for a
//   restart forced by the idle gap. Bytes taken while disabled give nothing.
//   An accepted byte's result is on the master side in the next cycle; the
//   rate is one word per cycle while the master side takes results, set by
//   the single state update of the parser between the input handshake and the result register.
//   A result waiting in the output register does not block input as long as
//   the master side takes it in the same cycle; when the master side stalls,
//   tready on the slave side drops until the result is taken.
//   Reset leaves the receiver disabled, the gap timeout at 100 ticks, the
//   parser waiting for STX and the output register empty.
//   Configuration: cfg_index 0 is the enable bit (a write of 1 restarts the
//   parser and clears the idle counter), cfg_index 1 is the gap timeout.
`default_nettype none

module stx_etx_frame_receiver (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave side
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire logic        s_axis_tuser,   // [0] opcode
    // master side
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // [7:0] payload_byte, [15:8] frame_type,
                                             // [23:16] frame_command, [39:24] frame_length,
                                             // [41:40] frame_status, [42] gap_restart, zero pad
    output logic             m_axis_tlast,   // payload_last
    output logic             m_axis_tuser,   // [0] payload_valid
    // configuration
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    import stxrx_pkg::*;

    // Configuration registers
    logic        enable_reg;
    logic [15:0] timeout_reg;

    // Parser state
    phase_t      phase_reg,   phase_next;
    logic [7:0]  xor_reg,     xor_next;
    logic [7:0]  type_reg,    type_next;
    logic [7:0]  cmd_reg,     cmd_next;
    logic [15:0] length_reg,  length_next;
    logic [15:0] count_reg,   count_next;
    logic [7:0]  check_reg,   check_next;
    logic [15:0] idle_reg,    idle_next;

    // Output register
    logic        out_valid_reg;
    result_t     out_data_reg;
    logic        out_last_reg;
    logic        out_pv_reg;

    logic        in_accept;
    logic        byte_taken;
    result_t     res_next;
    logic        last_next;
    logic        pv_next;
    phase_t      phase_eff;
    logic [15:0] count_inc;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign byte_taken    = in_accept && (s_axis_tuser == OP_BYTE) && enable_reg;
    assign count_inc     = count_reg + 16'd1;

    // Compute next parser state and the result word for one input word
    always_comb
    begin
        phase_next  = phase_reg;
        xor_next    = xor_reg;
        type_next   = type_reg;
        cmd_next    = cmd_reg;
        length_next = length_reg;
        count_next  = count_reg;
        check_next  = check_reg;
        idle_next   = idle_reg;
        pv_next     = 1'b0;
        last_next   = 1'b0;
        res_next    = '0;
        phase_eff   = phase_reg;

        if (in_accept && (s_axis_tuser == OP_TICK))
        begin
            if (idle_reg != 16'hFFFF)
                idle_next = idle_reg + 16'd1;
        end
        else if (byte_taken)
        begin
            // restart on a long idle gap before parsing this byte
            if (idle_reg >= timeout_reg)
            begin
                phase_eff            = PH_STX;
                res_next.gap_restart = 1'b1;
            end
            idle_next  = '0;
            phase_next = phase_eff;

            unique case (phase_eff)
                PH_STX:
                begin
                    if (s_axis_tdata == STX_BYTE)
                    begin
                        xor_next   = s_axis_tdata;
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    type_next  = s_axis_tdata;
                    xor_next   = xor_reg ^ s_axis_tdata;
                    phase_next = PH_CMD;
                end
                PH_CMD:
                begin
                    cmd_next   = s_axis_tdata;
                    xor_next   = xor_reg ^ s_axis_tdata;
                    phase_next = PH_LENL;
                end
                PH_LENL:
                begin
                    length_next = {8'd0, s_axis_tdata};
                    xor_next    = xor_reg ^ s_axis_tdata;
                    phase_next  = PH_LENH;
                end
                PH_LENH:
                begin
                    length_next = {s_axis_tdata, length_reg[7:0]};
                    xor_next    = xor_reg ^ s_axis_tdata;
                    count_next  = '0;
                    phase_next  = ({s_axis_tdata, length_reg[7:0]} != 16'd0) ? PH_DATA
                                                                             : PH_CHECK;
                end
                PH_DATA:
                begin
                    xor_next              = xor_reg ^ s_axis_tdata;
                    count_next            = count_inc;
                    pv_next               = 1'b1;
                    res_next.payload_byte = s_axis_tdata;
                    if (count_inc == length_reg)
                    begin
                        last_next  = 1'b1;
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    check_next = s_axis_tdata;
                    phase_next = PH_ETX;
                end
                PH_ETX:
                begin
                    if (s_axis_tdata != ETX_BYTE)
                        res_next.frame_status = ST_BAD_ETX;
                    else if (xor_reg != check_reg)
                        res_next.frame_status = ST_BAD_SUM;
                    else
                        res_next.frame_status = ST_GOOD;
                    phase_next = PH_STX;
                end
                default:
                begin
                    phase_next = PH_STX;
                end
            endcase
        end

        res_next.frame_type    = type_next;
        res_next.frame_command = cmd_next;
        res_next.frame_length  = length_next;

        // an enable write of 1 restarts the parser
        if (cfg_we && (cfg_index == CFG_ENABLE) && cfg_data[0])
        begin
            phase_next = PH_STX;
            idle_next  = '0;
        end
    end

    // Hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b0;
            timeout_reg <= GAP_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENABLE:  enable_reg  <= cfg_data[0];
                CFG_TIMEOUT: timeout_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Advance parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_STX;
            xor_reg    <= '0;
            type_reg   <= '0;
            cmd_reg    <= '0;
            length_reg <= '0;
            count_reg  <= '0;
            check_reg  <= '0;
            idle_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            xor_reg    <= xor_next;
            type_reg   <= type_next;
            cmd_reg    <= cmd_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            check_reg  <= check_next;
            idle_reg   <= idle_next;
        end
    end

    // Output valid: load on a taken byte, drop when the word is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (byte_taken)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (byte_taken)
        begin
            out_data_reg <= res_next;
            out_last_reg <= last_next;
            out_pv_reg   <= pv_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_pv_reg;

    // A free output register always lets input through
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty output register");

    // Every byte taken while enabled yields a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        byte_taken |=> m_axis_tvalid)
        else $error("taken byte produced no result");

    // Status and payload never share a result word
    a_status_not_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[41:40] != ST_NONE)) |-> !m_axis_tuser)
        else $error("status reported on a payload word");

    // Last marker only on payload words
    a_last_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
        else $error("tlast on a non-payload word");

    // Payload count stays below the held length while in the payload phase
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (count_reg < length_reg))
        else $error("payload count overran frame length");

endmodule

`default_nettype wire
